// ===== hdl/kvi_pkg.sv =====
package kvi_pkg;

  // Signed Q16.16 word as used for times and vector components.
  typedef logic signed [31:0] q16_t;

  // Request kinds carried on s_tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result kinds carried on m_tuser.
  localparam logic [1:0] CASE_FALLBACK = 2'd0;
  localparam logic [1:0] CASE_FIRST    = 2'd1;
  localparam logic [1:0] CASE_BLEND    = 2'd2;
  localparam logic [1:0] CASE_LAST     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_COUNT  = 2'd0;
  localparam logic [1:0] REG_FALLBACK_X = 2'd1;
  localparam logic [1:0] REG_FALLBACK_Y = 2'd2;
  localparam logic [1:0] REG_FALLBACK_Z = 2'd3;

  // Field widths of the stream payloads.
  localparam int KEY_INDEX_W = 6;
  localparam int KEY_COUNT_W = 7;
  localparam int VEC_W       = 96;
  localparam int IN_DATA_W   = 136;

endpackage

// ===== hdl/kvi_ram.sv =====
module kvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/keyframe_vector_interpolator_top.sv =====
// Keyframe vector interpolator. A load request (s_tuser = 0) writes one
// keyframe, a Q16.16 time and an x/y/z vector, into entry key_index of the
// table and gives no result; a query request (s_tuser = 1) gives exactly one
// result: the fallback vector when key_count is zero, entry 0 when there is
// one key or the query time is at or before the first key time, a linear
// blend of the first adjacent pair whose times bracket the query, or the last
// entry when no pair brackets it. Keys are expected in ascending time order
// and every entry below key_count must have been loaded before a query. A
// query first reads the first key time. The time memory is scanned one
// entry per cycle. A restoring divider makes the FRAC_BITS + 1 bits of the
// blend factor one bit per cycle. S_VA and S_VB then fetch the pair's
// vectors. One shared multiplier blends the three components in turn, each
// with a multiply and an add. S_DONE hands the result over, and the next
// request can be taken in the cycle after that. A new request is taken
// while the previous result still waits on the master side. Configuration
// writes are always taken and must only be issued while the block is idle.
module keyframe_vector_interpolator_top #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, from bit 0: key_index[5:0], time_value[37:6], value_x[69:38],
  // value_y[101:70], value_z[133:102], zero fill [135:134].
  input  logic [135:0] s_tdata,
  // s_tuser: cmd (0 load, 1 query).
  input  logic         s_tuser,
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, from bit 0: out_x[31:0], out_y[63:32], out_z[95:64].
  output logic [95:0]  m_tdata,
  // m_tuser: case_taken (0 fallback, 1 first key, 2 blend, 3 last key).
  output logic [1:0]   m_tuser,
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CNW = $clog2(MAX_KEYS + 1);
  localparam int SCW = $clog2(FRAC_BITS + 1);
  localparam int PW  = 35 + FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_VA    = 4'd4;
  localparam logic [3:0] S_VB    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_VONE  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;

  // Configuration registers.
  logic [kvi_pkg::KEY_COUNT_W-1:0] key_count;
  kvi_pkg::q16_t fallback_x;
  kvi_pkg::q16_t fallback_y;
  kvi_pkg::q16_t fallback_z;

  // Request fields.
  logic                            in_cmd;
  logic [kvi_pkg::KEY_INDEX_W-1:0] in_index;
  kvi_pkg::q16_t                   in_time;
  logic [kvi_pkg::VEC_W-1:0]       in_vec;
  logic                            in_accept;

  assign in_cmd    = s_tuser;
  assign in_index  = s_tdata[5:0];
  assign in_time   = s_tdata[37:6];
  assign in_vec    = s_tdata[133:38];
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Working registers of one query.
  kvi_pkg::q16_t        query_time;
  kvi_pkg::q16_t        prev_time;
  logic [CNW-1:0]       key_num;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        lo_idx;
  logic [32:0]          div_rem;
  logic [31:0]          div_span;
  logic [FRAC_BITS:0]   div_quo;
  logic [SCW-1:0]       div_cnt;
  kvi_pkg::q16_t        vec_a [3];
  logic signed [32:0]   vec_d [3];
  kvi_pkg::q16_t        res [3];
  logic [1:0]           res_case;
  logic [1:0]           comp;
  logic signed [PW-1:0] prod;

  // Memories: key times, and key vectors packed x in the low bits.
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             t_raddr;
  logic [AW-1:0]             v_raddr;
  kvi_pkg::q16_t             t_rdata;
  logic [kvi_pkg::VEC_W-1:0] v_rdata;

  assign ram_we = in_accept && (in_cmd == kvi_pkg::CMD_LOAD)
                  && (32'(in_index) < MAX_KEYS);
  assign ram_waddr = AW'(in_index);

  kvi_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kvi_ram #(.WIDTH(kvi_pkg::VEC_W), .DEPTH(MAX_KEYS)) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_vec),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // A key_count beyond the table size acts as the table size.
  logic [CNW-1:0] key_num_clamp;
  assign key_num_clamp = (32'(key_count) > MAX_KEYS) ? CNW'(MAX_KEYS) : CNW'(key_count);

  logic [AW-1:0] last_idx;
  assign last_idx = AW'(key_num - CNW'(1));

  // Scan compare: the pair (idx-1, idx) brackets the query.
  logic               scan_hit;
  logic               scan_last;
  logic signed [32:0] span_wide;
  logic signed [32:0] diff_wide;

  assign scan_hit  = (prev_time <= query_time) && (query_time <= t_rdata);
  assign scan_last = (idx == last_idx);
  assign span_wide = {t_rdata[31], t_rdata} - {prev_time[31], prev_time};
  assign diff_wide = {query_time[31], query_time} - {prev_time[31], prev_time};

  // Restoring division step: one quotient bit per cycle.
  logic              div_ge;
  logic [32:0]       div_sub;
  logic [FRAC_BITS:0] div_quo_next;

  assign div_ge       = (div_rem >= {1'b0, div_span});
  assign div_sub      = div_ge ? (div_rem - {1'b0, div_span}) : div_rem;
  assign div_quo_next = {div_quo[FRAC_BITS-1:0], div_ge};

  // Blend datapath; the arithmetic shift of the product is a floor.
  logic signed [FRAC_BITS+1:0] blend_t;
  logic signed [PW-1:0]        prod_sh;

  assign blend_t = $signed({1'b0, div_quo});
  assign prod_sh = prod >>> FRAC_BITS;

  // Read addresses are steered from the state so that data is ready in
  // the following state.
  always_comb begin
    t_raddr = '0;
    v_raddr = '0;
    unique case (state)
      S_FIRST: begin
        t_raddr = AW'(1);
        v_raddr = '0;
      end
      S_SCAN: begin
        t_raddr = idx + AW'(1);
        v_raddr = scan_hit ? (idx - AW'(1)) : last_idx;
      end
      S_DIV:   v_raddr = lo_idx;
      S_VA:    v_raddr = lo_idx + AW'(1);
      default: begin
        t_raddr = '0;
        v_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count  <= '0;
      fallback_x <= '0;
      fallback_y <= '0;
      fallback_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kvi_pkg::REG_KEY_COUNT:  key_count  <= cfg_data[kvi_pkg::KEY_COUNT_W-1:0];
        kvi_pkg::REG_FALLBACK_X: fallback_x <= cfg_data;
        kvi_pkg::REG_FALLBACK_Y: fallback_y <= cfg_data;
        kvi_pkg::REG_FALLBACK_Z: fallback_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // In S_DONE a result taken this cycle is replaced by the new one there.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (in_cmd == kvi_pkg::CMD_QUERY)) begin
            query_time <= in_time;
            key_num    <= key_num_clamp;
            if (key_num_clamp == '0) begin
              res[0]   <= fallback_x;
              res[1]   <= fallback_y;
              res[2]   <= fallback_z;
              res_case <= kvi_pkg::CASE_FALLBACK;
              state    <= S_DONE;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if ((key_num == CNW'(1)) || (query_time <= t_rdata)) begin
            res_case <= kvi_pkg::CASE_FIRST;
            state    <= S_VONE;
          end else begin
            prev_time <= t_rdata;
            idx       <= AW'(1);
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            lo_idx   <= idx - AW'(1);
            div_rem  <= diff_wide;
            div_span <= span_wide[31:0];
            div_cnt  <= SCW'(FRAC_BITS);
            div_quo  <= '0;
            // A zero span blends with a factor of zero.
            state    <= (span_wide == '0) ? S_VA : S_DIV;
          end else if (scan_last) begin
            res_case <= kvi_pkg::CASE_LAST;
            state    <= S_VONE;
          end else begin
            prev_time <= t_rdata;
            idx       <= idx + AW'(1);
          end
        end
        S_DIV: begin
          div_rem <= {div_sub[31:0], 1'b0};
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - SCW'(1);
          if (div_cnt == '0) begin
            state <= S_VA;
          end
        end
        S_VA: begin
          vec_a[0] <= v_rdata[31:0];
          vec_a[1] <= v_rdata[63:32];
          vec_a[2] <= v_rdata[95:64];
          state    <= S_VB;
        end
        S_VB: begin
          vec_d[0] <= {v_rdata[31], v_rdata[31:0]}  - {vec_a[0][31], vec_a[0]};
          vec_d[1] <= {v_rdata[63], v_rdata[63:32]} - {vec_a[1][31], vec_a[1]};
          vec_d[2] <= {v_rdata[95], v_rdata[95:64]} - {vec_a[2][31], vec_a[2]};
          comp     <= 2'd0;
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= vec_d[comp] * blend_t;
          state <= S_ADD;
        end
        S_ADD: begin
          // The blended value stays between the two keys, so 32 bits suffice.
          res[comp] <= vec_a[comp] + prod_sh[31:0];
          if (comp == 2'd2) begin
            res_case <= kvi_pkg::CASE_BLEND;
            state    <= S_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_VONE: begin
          res[0] <= v_rdata[31:0];
          res[1] <= v_rdata[63:32];
          res[2] <= v_rdata[95:64];
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res[2], res[1], res[0]};
            m_tuser  <= res_case;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
